@@ sv/atca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atca_pkg
// Shared types and constants of the temperature convert and average block.
// ----------------------------------------------------------------------------
package atca_pkg;

    // sensor front end
    localparam int CAL_SUPPLY_MV = 3000;
    localparam int CODE_BITS     = 12;
    localparam int BAND_LIMIT    = 20000;

    // shared divider geometry
    localparam int DIV_NUM_W = 41;   // numerator magnitude bits
    localparam int DIV_DEN_W = 24;   // divisor magnitude bits
    localparam int DIV_QUO_W = 32;   // quotient bits produced
    localparam int DIV_CNT_W = $clog2(DIV_QUO_W);

    // job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [2:0] {
        CFG_CAL1_CODE   = 3'd0,
        CFG_CAL2_CODE   = 3'd1,
        CFG_CAL1_TEMP   = 3'd2,
        CFG_CAL2_TEMP   = 3'd3,
        CFG_SUPPLY_MV   = 3'd4,
        CFG_MIN_TEMP    = 3'd5,
        CFG_MAX_TEMP    = 3'd6,
        CFG_SAMPLES_AVG = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [11:0] cal1_code;
        logic        [11:0] cal2_code;
        logic signed [8:0]  cal1_temp;
        logic signed [8:0]  cal2_temp;
        logic        [11:0] supply_mv;
        logic signed [15:0] min_temp;
        logic signed [15:0] max_temp;
        logic        [7:0]  samples_avg;
    } t_cfg;

    // one classified sample waiting for the back end
    typedef struct packed {
        logic                 valid;     // sample can be converted at all
        logic                 neg;       // sign of the slope term
        logic [DIV_NUM_W-1:0] num_mag;
        logic [DIV_DEN_W-1:0] den_mag;
    } t_job;

endpackage

@@ sv/adc_temperature_convert_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_temperature_convert_average
// Two-point calibrated temperature conversion with windowed averaging.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  input     push / full       i_adc_code, i_conversion_ok
//  result    empty / pop       o_mean_temp, o_status, o_valid_count
//  config    i_cfg_we          i_cfg_idx, i_cfg_wdata
//
//  The front takes one sample at a time into a 2-deep job queue. The back
//  runs each converted sample through the 32-step divider, takes a failed
//  one straight to the window update, and on a window close divides again
//  for the mean, or goes straight to the output if no sample was valid.
//  Reset restores the calibration defaults and clears the window; no sweep.
//  A result waiting on pop holds the back once the next mean is ready.
// ----------------------------------------------------------------------------
module adc_temperature_convert_average (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [11:0]        i_adc_code,
    input  logic               i_conversion_ok,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_mean_temp,
    output logic               o_status,
    output logic [7:0]         o_valid_count,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata
);
    import atca_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job queue_job;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal1_code   <= 12'd1024;
            r_cfg.cal2_code   <= 12'd1360;
            r_cfg.cal1_temp   <= 9'sd30;
            r_cfg.cal2_temp   <= 9'sd130;
            r_cfg.supply_mv   <= 12'd3300;
            r_cfg.min_temp    <= -16'sd4000;
            r_cfg.max_temp    <= 16'sd12500;
            r_cfg.samples_avg <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAL1_CODE:   r_cfg.cal1_code   <= i_cfg_wdata[11:0];
                CFG_CAL2_CODE:   r_cfg.cal2_code   <= i_cfg_wdata[11:0];
                CFG_CAL1_TEMP:   r_cfg.cal1_temp   <= i_cfg_wdata[8:0];
                CFG_CAL2_TEMP:   r_cfg.cal2_temp   <= i_cfg_wdata[8:0];
                CFG_SUPPLY_MV:   r_cfg.supply_mv   <= i_cfg_wdata[11:0];
                CFG_MIN_TEMP:    r_cfg.min_temp    <= i_cfg_wdata;
                CFG_MAX_TEMP:    r_cfg.max_temp    <= i_cfg_wdata;
                CFG_SAMPLES_AVG: r_cfg.samples_avg <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    atca_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .push            (push),
        .full            (full),
        .i_adc_code      (i_adc_code),
        .i_conversion_ok (i_conversion_ok),
        .o_job           (front_job),
        .o_job_push      (front_push),
        .i_job_full      (queue_full)
    );

    atca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    atca_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job         (queue_job),
        .i_job_empty   (queue_empty),
        .o_job_pop     (back_pop),
        .empty         (empty),
        .pop           (pop),
        .o_mean_temp   (o_mean_temp),
        .o_status      (o_status),
        .o_valid_count (o_valid_count)
    );

endmodule

@@ sv/atca_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atca_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [atca_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [atca_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [atca_pkg::DIV_QUO_W-1:0] o_quo
);
    import atca_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den, n_den;
    logic [DIV_QUO_W-1:0] r_sh, n_sh;     // numerator bits out, quotient bits in
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // partial remainder stays below the divisor, so one extra bit is enough
    assign trial = {r_rem, r_sh[DIV_QUO_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_sh   = r_sh;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_QUO_W - 1);
            n_rem  = DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_QUO_W]);
            n_den  = i_den;
            n_sh   = i_num[DIV_QUO_W-1:0];
        end else if (r_busy) begin
            n_rem = fits ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            n_sh  = {r_sh[DIV_QUO_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_sh  <= n_sh;
    end

    assign o_done = r_done;
    assign o_quo  = r_sh;

endmodule

@@ sv/atca_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atca_front
// Accepts raw conversions, checks them and forms the slope division operands.
// ----------------------------------------------------------------------------
module atca_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atca_pkg::t_cfg       i_cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [11:0]          i_adc_code,
    input  logic                 i_conversion_ok,
    output atca_pkg::t_job       o_job,
    output logic                 o_job_push,
    input  logic                 i_job_full
);
    import atca_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam logic [11:0] CODE_MASK = 12'((1 << CODE_BITS) - 1);

    t_fstate            r_state, n_state;
    logic        [23:0] r_cs;       // code times supply
    logic        [23:0] r_cal1x;    // first cal code times nominal supply
    logic signed [16:0] r_dt100;
    logic signed [24:0] r_den;
    logic               r_ok;
    logic signed [41:0] r_num;

    logic        [11:0] code_m;
    logic signed [9:0]  dt;
    logic signed [12:0] dcode;
    logic signed [24:0] diff;
    logic        [41:0] num_abs;
    logic        [24:0] den_abs;
    logic               take;

    assign take   = push && (r_state == F_IDLE);
    assign full   = (r_state != F_IDLE);
    assign code_m = i_adc_code & CODE_MASK;
    assign dt     = 10'(i_cfg.cal2_temp) - 10'(i_cfg.cal1_temp);
    assign dcode  = $signed({1'b0, i_cfg.cal2_code}) - $signed({1'b0, i_cfg.cal1_code});
    assign diff   = $signed({1'b0, r_cs}) - $signed({1'b0, r_cal1x});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (take) n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (!i_job_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (take) begin
            r_cs    <= {12'b0, code_m} * {12'b0, i_cfg.supply_mv};
            r_cal1x <= 24'({12'b0, i_cfg.cal1_code} * 24'(CAL_SUPPLY_MV));
            r_dt100 <= 17'(dt * 100);
            r_den   <= 25'(dcode * CAL_SUPPLY_MV);
            r_ok    <= i_conversion_ok && (i_cfg.cal1_code != i_cfg.cal2_code);
        end
        if (r_state == F_MUL) begin
            r_num <= r_dt100 * diff;
        end
    end

    assign num_abs = r_num[41] ? 42'(-r_num) : 42'(r_num);
    assign den_abs = r_den[24] ? 25'(-r_den) : 25'(r_den);

    always_comb begin
        o_job.valid   = r_ok;
        o_job.neg     = r_num[41] ^ r_den[24];
        o_job.num_mag = num_abs[DIV_NUM_W-1:0];
        o_job.den_mag = den_abs[DIV_DEN_W-1:0];
    end

    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

endmodule

@@ sv/atca_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atca_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module atca_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atca_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output atca_pkg::t_job o_job,
    output logic           o_empty
);
    import atca_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wptr;
    logic [JOB_PTR_W-1:0] r_rptr;
    logic [JOB_CNT_W-1:0] r_count;
    logic                 wr, rd;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) r_wptr <= r_wptr + 1'b1;
            if (rd) r_rptr <= r_rptr + 1'b1;
            r_count <= r_count + JOB_CNT_W'(wr) - JOB_CNT_W'(rd);
        end
        if (wr) r_mem[r_wptr] <= i_job;
    end

endmodule

@@ sv/atca_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atca_back
// Finishes each sample conversion, accumulates the window and forms the mean.
// ----------------------------------------------------------------------------
module atca_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atca_pkg::t_cfg     i_cfg,
    input  atca_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_mean_temp,
    output logic               o_status,
    output logic [7:0]         o_valid_count
);
    import atca_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_SDIV = 5'b00010,
        B_ACC  = 5'b00100,
        B_MDIV = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    t_bstate            r_state, n_state;
    logic               r_neg;
    logic               r_take;
    logic signed [15:0] r_t;
    logic signed [23:0] r_sum;
    logic        [7:0]  r_acc;
    logic        [7:0]  r_seen;
    logic               r_mean_neg;
    logic signed [15:0] r_res_mean;
    logic               r_res_status;
    logic        [7:0]  r_res_count;
    logic               r_out_valid;
    logic signed [15:0] r_out_mean;
    logic               r_out_status;
    logic        [7:0]  r_out_count;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_QUO_W-1:0] div_quo;

    logic signed [16:0] base;
    logic signed [33:0] sq, t_raw, t_lo, t_cl;
    logic signed [33:0] min34, max34;
    logic               in_band;
    logic signed [23:0] n_sum;
    logic        [7:0]  n_acc;
    logic        [8:0]  n_seen;
    logic        [7:0]  window;
    logic               close;
    logic        [23:0] sum_abs;
    logic        [15:0] q16;
    logic               out_load;

    atca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // sample value: 100*cal1_temp plus the signed slope quotient, then clamp
    assign base    = 17'(i_cfg.cal1_temp * 100);
    assign sq      = r_neg ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
    assign t_raw   = sq + 34'(base);
    assign min34   = 34'(i_cfg.min_temp);
    assign max34   = 34'(i_cfg.max_temp);
    assign t_lo    = (t_raw < min34) ? min34 : t_raw;
    assign t_cl    = (t_lo > max34) ? max34 : t_lo;
    assign in_band = (t_cl > 34'(-BAND_LIMIT)) && (t_cl < 34'(BAND_LIMIT));

    // window bookkeeping
    assign n_sum   = r_sum + (r_take ? 24'(r_t) : 24'sd0);
    assign n_acc   = r_acc + 8'(r_take);
    assign n_seen  = {1'b0, r_seen} + 9'd1;
    assign window  = (i_cfg.samples_avg == 8'd0) ? 8'd1 : i_cfg.samples_avg;
    assign close   = n_seen >= {1'b0, window};
    assign sum_abs = n_sum[23] ? 24'(-n_sum) : 24'(n_sum);
    assign q16     = div_quo[15:0];

    assign out_load = (r_state == B_OUT) && (!r_out_valid || pop);

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        div_start = 1'b0;
        div_num   = i_job.num_mag;
        div_den   = i_job.den_mag;
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    if (i_job.valid) begin
                        div_start = 1'b1;
                        n_state   = B_SDIV;
                    end else begin
                        n_state = B_ACC;
                    end
                end
            end
            B_SDIV: if (div_done) n_state = B_ACC;
            B_ACC: begin
                if (close && n_acc != 8'd0) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'(sum_abs);
                    div_den   = DIV_DEN_W'(n_acc);
                    n_state   = B_MDIV;
                end else if (close) begin
                    n_state = B_OUT;
                end else begin
                    n_state = B_IDLE;
                end
            end
            B_MDIV: if (div_done) n_state = B_OUT;
            B_OUT:  if (out_load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum       <= '0;
            r_acc       <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ACC) begin
                if (close) begin
                    r_sum  <= '0;
                    r_acc  <= '0;
                    r_seen <= '0;
                end else begin
                    r_sum  <= n_sum;
                    r_acc  <= n_acc;
                    r_seen <= n_seen[7:0];
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end

        if (r_state == B_IDLE) begin
            r_neg  <= i_job.neg;
            r_take <= 1'b0;
        end
        if (r_state == B_SDIV && div_done) begin
            r_take <= in_band;
            r_t    <= t_cl[15:0];
        end
        if (r_state == B_ACC) begin
            r_mean_neg   <= n_sum[23];
            r_res_count  <= n_acc;
            r_res_mean   <= '0;
            r_res_status <= (n_acc == 8'd0);
        end
        if (r_state == B_MDIV && div_done) begin
            r_res_mean <= r_mean_neg ? 16'(-q16) : 16'(q16);
        end
        if (out_load) begin
            r_out_mean   <= r_res_mean;
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
        end
    end

    assign empty         = !r_out_valid;
    assign o_mean_temp   = r_out_mean;
    assign o_status      = r_out_status;
    assign o_valid_count = r_out_count;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the calibrated temperature convert and average block.
// Random and directed sensor samples go in through the push side. Each
// accepted sample is run through a local two-point calibration model, and
// each window mean that the block delivers is compared field by field.
// Calibration, clamp and window settings change between phases, only while
// the block is idle.
// ----------------------------------------------------------------------------
import atca_pkg::*;

typedef struct {
    logic signed [15:0] mean_temp;
    logic               status;
    logic [7:0]         valid_count;
} mean_result_t;

localparam logic STATUS_MEAN_OK    = 1'b0;
localparam logic STATUS_NO_SAMPLES = 1'b1;

class temp_average_scoreboard;
    // calibration and window settings as the block holds them
    int unsigned cal1_code;
    int unsigned cal2_code;
    int          cal1_temp;
    int          cal2_temp;
    int unsigned supply_mv;
    int          min_temp;
    int          max_temp;
    int unsigned samples_avg;

    // running window
    int          window_sum;
    int unsigned window_accepted;
    int unsigned window_seen;

    mean_result_t expected_means[$];
    int errors;
    int shown;
    int samples_seen;
    int means_checked;

    function new();
        cal1_code       = 1024;
        cal2_code       = 1360;
        cal1_temp       = 30;
        cal2_temp       = 130;
        supply_mv       = 3300;
        min_temp        = -4000;
        max_temp        = 12500;
        samples_avg     = 1;
        window_sum      = 0;
        window_accepted = 0;
        window_seen     = 0;
        errors          = 0;
        shown           = 0;
        samples_seen    = 0;
        means_checked   = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [15:0] data);
        case (idx)
            CFG_CAL1_CODE:   cal1_code = data[11:0];
            CFG_CAL2_CODE:   cal2_code = data[11:0];
            CFG_CAL1_TEMP:   cal1_temp = int'($signed(data[8:0]));
            CFG_CAL2_TEMP:   cal2_temp = int'($signed(data[8:0]));
            CFG_SUPPLY_MV:   supply_mv = data[11:0];
            CFG_MIN_TEMP:    min_temp  = int'($signed(data));
            CFG_MAX_TEMP:    max_temp  = int'($signed(data));
            CFG_SAMPLES_AVG: samples_avg = data[7:0];
        endcase
    endfunction

    // returns 1 when the sample lands inside the band, value in 0.01 deg C
    function bit calibrated_temp(logic [11:0] code, logic ok, output int t_out);
        longint slope_num;
        longint slope_den;
        longint t;
        t_out = 0;
        if (!ok || cal1_code == cal2_code)
            return 1'b0;
        slope_num = 64'sd100 * longint'(cal2_temp - cal1_temp)
                  * (longint'(code) * longint'(supply_mv)
                     - longint'(cal1_code) * longint'(CAL_SUPPLY_MV));
        slope_den = (longint'(cal2_code) - longint'(cal1_code))
                  * longint'(CAL_SUPPLY_MV);
        t = 64'sd100 * longint'(cal1_temp) + slope_num / slope_den;
        if (t < longint'(min_temp))
            t = min_temp;
        // upper clamp last, so crossed limits give max_temp
        if (t > longint'(max_temp))
            t = max_temp;
        if (t <= -longint'(BAND_LIMIT) || t >= longint'(BAND_LIMIT))
            return 1'b0;
        t_out = int'(t);
        return 1'b1;
    endfunction

    function void note_sample(logic [11:0] code, logic ok);
        int           t;
        int unsigned  window;
        mean_result_t r;
        samples_seen++;
        window = (samples_avg == 0) ? 1 : samples_avg;
        if (calibrated_temp(code, ok, t)) begin
            window_sum += t;
            window_accepted++;
        end
        window_seen++;
        if (window_seen < window)
            return;
        if (window_accepted == 0) begin
            r.mean_temp   = 16'sd0;
            r.status      = STATUS_NO_SAMPLES;
            r.valid_count = 8'd0;
        end else begin
            r.mean_temp   = 16'(window_sum / int'(window_accepted));
            r.status      = STATUS_MEAN_OK;
            r.valid_count = 8'(window_accepted);
        end
        expected_means.push_back(r);
        window_sum      = 0;
        window_accepted = 0;
        window_seen     = 0;
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (shown < 40) begin
            shown++;
            $display("[%0t] mean #%0d: %s", $time, means_checked, msg);
        end
    endtask

    task check_result(logic signed [15:0] mean_temp, logic status,
                      logic [7:0] valid_count);
        mean_result_t e;
        means_checked++;
        if (expected_means.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction mean=%0d status=%0d count=%0d",
                                      mean_temp, status, valid_count));
            return;
        end
        e = expected_means.pop_front();
        if (mean_temp !== e.mean_temp)
            report_mismatch($sformatf("mean_temp %0d, want %0d", mean_temp, e.mean_temp));
        if (status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status, e.status));
        if (valid_count !== e.valid_count)
            report_mismatch($sformatf("valid_count %0d, want %0d",
                                      valid_count, e.valid_count));
    endtask

    function int pending();
        return expected_means.size();
    endfunction
endclass

module tb_top;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS  = 1600;

    localparam t_cfg DEFAULT_CFG = '{
        cal1_code:   12'd1024,
        cal2_code:   12'd1360,
        cal1_temp:   9'sd30,
        cal2_temp:   9'sd130,
        supply_mv:   12'd3300,
        min_temp:    -16'sd4000,
        max_temp:    16'sd12500,
        samples_avg: 8'd1
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [11:0]        i_adc_code;
    logic               i_conversion_ok;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_mean_temp;
    logic               o_status;
    logic [7:0]         o_valid_count;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_wdata;

    temp_average_scoreboard sb = new();
    bit calm = 1'b0;
    int cycle_count = 0;
    int config_count = 0;

    adc_temperature_convert_average u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_adc_code      (i_adc_code),
        .i_conversion_ok (i_conversion_ok),
        .empty           (empty),
        .pop             (pop),
        .o_mean_temp     (o_mean_temp),
        .o_status        (o_status),
        .o_valid_count   (o_valid_count),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 19)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_extreme(int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    function automatic t_cfg random_cfg(bit large_window);
        t_cfg c;
        int   w;
        if (large_window || $urandom_range(0, 9) < 7) begin
            c.cal1_code = 12'($urandom_range(800, 1200));
            c.cal2_code = 12'(int'(c.cal1_code) + int'($urandom_range(150, 500)));
            c.cal1_temp = 9'($urandom_range(20, 40));
            c.cal2_temp = 9'($urandom_range(100, 140));
            c.supply_mv = 12'($urandom_range(2700, 3600));
            c.min_temp  = 16'(-int'($urandom_range(0, 6000)));
            c.max_temp  = 16'($urandom_range(8000, 20000));
        end else begin
            c.cal1_code = 12'(pick_extreme(0, 4095));
            c.cal2_code = 12'(pick_extreme(0, 4095));
            c.cal1_temp = 9'(pick_extreme(-64, 200));
            c.cal2_temp = 9'(pick_extreme(-64, 200));
            c.supply_mv = 12'(pick_extreme(1000, 4000));
            c.min_temp  = 16'(pick_extreme(-20000, 20000));
            c.max_temp  = 16'(pick_extreme(-20000, 20000));
        end
        if (!large_window && $urandom_range(0, 11) == 0)
            c.cal2_code = c.cal1_code;
        w = $urandom_range(0, 19);
        if (large_window)
            c.samples_avg = 8'd255;
        else if (w == 0)
            c.samples_avg = 8'd0;
        else if (w == 1)
            c.samples_avg = 8'd255;
        else if (w == 2)
            c.samples_avg = 8'($urandom_range(9, 40));
        else
            c.samples_avg = 8'($urandom_range(1, 8));
        return c;
    endfunction

    // codes mostly around the span the calibration points cover after scaling
    function automatic logic [11:0] random_code(t_cfg c);
        int lo;
        int hi;
        lo = (c.cal1_code < c.cal2_code) ? int'(c.cal1_code) : int'(c.cal2_code);
        hi = (c.cal1_code < c.cal2_code) ? int'(c.cal2_code) : int'(c.cal1_code);
        lo = lo * CAL_SUPPLY_MV / int'(c.supply_mv) - 100;
        hi = hi * CAL_SUPPLY_MV / int'(c.supply_mv) + 100;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        if ($urandom_range(0, 3) == 0 || lo >= hi)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(lo, hi));
    endfunction

    task automatic configure(input t_cfg c);
        t_cfg_idx r;
        r = r.first();
        i_cfg_we <= 1'b1;
        do begin
            i_cfg_idx <= r;
            case (r)
                CFG_CAL1_CODE:   i_cfg_wdata <= 16'(c.cal1_code);
                CFG_CAL2_CODE:   i_cfg_wdata <= 16'(c.cal2_code);
                CFG_CAL1_TEMP:   i_cfg_wdata <= {{7{c.cal1_temp[8]}}, c.cal1_temp};
                CFG_CAL2_TEMP:   i_cfg_wdata <= {{7{c.cal2_temp[8]}}, c.cal2_temp};
                CFG_SUPPLY_MV:   i_cfg_wdata <= 16'(c.supply_mv);
                CFG_MIN_TEMP:    i_cfg_wdata <= c.min_temp;
                CFG_MAX_TEMP:    i_cfg_wdata <= c.max_temp;
                CFG_SAMPLES_AVG: i_cfg_wdata <= 16'(c.samples_avg);
            endcase
            @(posedge i_clk);
            r = r.next();
        end while (r != r.first());
        i_cfg_we <= 1'b0;
        config_count++;
    endtask

    // hold pauses the sender until every pending mean has been popped
    task automatic push_sample(input logic [11:0] code, input logic ok, input bit hold);
        int gap;
        gap = pick_gap();
        if (hold && gap == 0)
            gap = 1;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            while (hold && sb.pending() != 0)
                @(posedge i_clk);
        end
        push            <= 1'b1;
        i_adc_code      <= code;
        i_conversion_ok <= ok;
        @(posedge i_clk);
        while (full !== 1'b0)
            @(posedge i_clk);
    endtask

    // back end may still be busy on samples that close no window
    task automatic settle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls between pops
    initial begin
        int stall;
        stall = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop === 1'b1 && empty === 1'b0)
                stall = pick_gap();
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // transaction monitor, sampled at the same edge the block uses
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_we === 1'b1)
                sb.write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_wdata);
            if (push === 1'b1 && full === 1'b0)
                sb.note_sample(i_adc_code, i_conversion_ok);
            if (pop === 1'b1 && empty === 1'b0)
                sb.check_result(o_mean_temp, o_status, o_valid_count);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d means still pending",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_cfg        c;
        logic [11:0] edge_codes[$];
        int          target;
        int          n;
        int          phase;
        edge_codes = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd1024, 12'd1360, 12'd931};

        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_adc_code      <= '0;
        i_conversion_ok <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_CAL1_CODE;
        i_cfg_wdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: code extremes clamp to the default limits
        foreach (edge_codes[k])
            push_sample(edge_codes[k], 1'b1, 1'b0);
        push_sample(12'd1100, 1'b0, 1'b0);
        settle();

        // wide limits: extreme codes clamp onto the band edge and are rejected
        c = DEFAULT_CFG;
        c.min_temp = -16'sd20000;
        c.max_temp = 16'sd20000;
        configure(c);
        push_sample(12'd0, 1'b1, 1'b0);
        push_sample(12'd4095, 1'b1, 1'b0);
        settle();

        // crossed clamp limits
        c.min_temp = 16'sd5000;
        c.max_temp = -16'sd1000;
        configure(c);
        push_sample(12'd1000, 1'b1, 1'b0);
        push_sample(12'd1300, 1'b1, 1'b0);
        settle();

        // equal calibration codes, window of two with nothing valid
        c = DEFAULT_CFG;
        c.cal2_code   = c.cal1_code;
        c.samples_avg = 8'd2;
        configure(c);
        push_sample(12'd1100, 1'b1, 1'b0);
        push_sample(12'd1200, 1'b1, 1'b0);
        settle();

        // window cut short: two seen of four, then a window of zero
        c = DEFAULT_CFG;
        c.samples_avg = 8'd4;
        configure(c);
        push_sample(12'd1100, 1'b1, 1'b0);
        push_sample(12'd1200, 1'b1, 1'b0);
        settle();
        c.samples_avg = 8'd0;
        configure(c);
        push_sample(12'd1150, 1'b1, 1'b0);
        settle();

        target = sb.samples_seen + RANDOM_ITEMS;
        phase  = 0;
        while (sb.samples_seen < target) begin
            c    = random_cfg(phase == 0);
            calm = ($urandom_range(0, 3) == 0);
            n    = (c.samples_avg == 8'd255) ? $urandom_range(256, 300)
                                             : $urandom_range(20, 120);
            configure(c);
            repeat (n)
                push_sample(random_code(c), $urandom_range(0, 11) != 0,
                            $urandom_range(0, 149) == 0);
            settle();
            phase++;
        end
        calm = 1'b0;
        settle();

        $display("ran %0d samples under %0d register settings, %0d window means checked",
                 sb.samples_seen, config_count, sb.means_checked);
        $display("calibration, clamp, band, failed conversion and window length cases hit");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
